FILE: hdl/bns_pkg.sv
`default_nettype none
package bns_pkg;
  localparam int TILE_SIZE_DEF = 64;
  localparam logic [1:0] MODE_BRAILLE = 2'd0;
  localparam logic [1:0] MODE_OCTANT  = 2'd1;
  localparam logic [1:0] MODE_CELL    = 2'd2;
  localparam logic [13:0] GLYPH_SPACE = 14'h0020;
  localparam logic [13:0] GLYPH_DOT1  = 14'h00B7;
  localparam logic [13:0] GLYPH_DOT2  = 14'h2219;
  localparam logic [13:0] GLYPH_DOT3  = 14'h2022;
  localparam logic [13:0] GLYPH_DOT4  = 14'h25CF;
  localparam logic [13:0] GLYPH_BRAILLE = 14'h2800;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_DIV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [15:0] shade;
    logic [23:0] rgb;
    logic [2:0]  idx;
    logic        by_cell;
  } look_t;

  function automatic logic [7:0] braille_bit(input logic [2:0] i);
    logic [7:0] r;
    unique case (i)
      3'd0: r = 8'h01;
      3'd1: r = 8'h08;
      3'd2: r = 8'h02;
      3'd3: r = 8'h10;
      3'd4: r = 8'h04;
      3'd5: r = 8'h20;
      3'd6: r = 8'h40;
      default: r = 8'h80;
    endcase
    return r;
  endfunction

  function automatic logic [15:0] shade_of(input logic [23:0] rgb);
    logic [24:0] s;
    logic [41:0] q;
    logic [16:0] l;
    logic [24:0] rem;
    s = 25'(rgb[23:16]) * 25'd13933 + 25'(rgb[15:8]) * 25'd46871 +
        25'(rgb[7:0]) * 25'd4731;
    q = 42'(s) * 42'd65793;
    l = 17'(q >> 24);
    rem = s - 25'(l) * 25'd255;
    if (rem >= 25'd255) l = l + 17'd1;
    return 16'(17'd65535 - l);
  endfunction
endpackage
`default_nettype wire

FILE: hdl/bns_rank_mem.sv
`default_nettype none
module bns_rank_mem
  import bns_pkg::*;
#(
  parameter int AW = 12
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [7:0]    wdata,
  input  wire logic [AW-1:0] raddr,
  output logic [7:0]         rdata
);
  logic [7:0] mem [2**AW];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: hdl/bns_divider.sv
`default_nettype none
module bns_divider
  import bns_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [10:0] num,
  input  wire logic [3:0]  den,
  output logic             done,
  output logic [7:0]       quo
);
  logic [10:0] q;
  logic [3:0]  r;
  logic [3:0]  cnt;
  logic        busy;
  logic [4:0]  t;
  assign t = {r, q[10]};
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        q <= num;
        r <= '0;
        cnt <= 4'd0;
      end else if (busy) begin
        if (t >= {1'b0, den}) begin
          r <= 4'(t - {1'b0, den});
          q <= {q[9:0], 1'b1};
        end else begin
          r <= t[3:0];
          q <= {q[9:0], 1'b0};
        end
        cnt <= cnt + 4'd1;
        if (cnt == 4'd10) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
  assign quo = q[7:0];
endmodule
`default_nettype wire

FILE: hdl/blue_noise_stipple_cell_unit.sv
`default_nettype none
// Channel  Dir  Beat contents
// s_axis   in   tuser: command; tdata: noise fields, cell position, index, colours
// m_axis   out  tdata: glyph_code, dot_pattern, new_fg, new_bg
// cfg      in   stipple_mode, written by cfg_we
// A rank write leaves the unit idle; a sample passes a rank memory read, then the update.
// A cell-ending sample in braille or octant mode then runs six colour divisions, one after
// another, in a shared unit. In cell mode the result beat follows at once.
// The input stalls while a result beat waits on m_axis_tready.
// Reset is synchronous and clears the accumulators; the rank memory holds no reset value.
module blue_noise_stipple_cell_unit
  import bns_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_we,
  input  wire logic [1:0]   cfg_data,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // command
  input  wire logic         s_axis_tuser,
  // noise_address, noise_value, cell_column, cell_line, sample_index,
  // sample_rgb, old_fg, old_bg, zero padding
  input  wire logic [119:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // glyph_code, dot_pattern, new_fg, new_bg, zero padding
  output logic [71:0]       m_axis_tdata
);
  localparam int TILE_SIZE = TILE_SIZE_DEF;
  localparam int TB = $clog2(TILE_SIZE);
  localparam int AW = 2 * TB;
  localparam int ENTRIES = TILE_SIZE * TILE_SIZE;

  logic [11:0] in_naddr, in_col, in_line;
  logic [7:0]  in_nval;
  logic [2:0]  in_idx;
  logic [23:0] in_rgb, in_fg, in_bg;
  assign in_naddr = s_axis_tdata[11:0];
  assign in_nval  = s_axis_tdata[19:12];
  assign in_col   = s_axis_tdata[31:20];
  assign in_line  = s_axis_tdata[43:32];
  assign in_idx   = s_axis_tdata[46:44];
  assign in_rgb   = s_axis_tdata[70:47];
  assign in_fg    = s_axis_tdata[94:71];
  assign in_bg    = s_axis_tdata[118:95];

  logic [1:0] mode;
  always_ff @(posedge clk) begin
    if (rst) mode <= MODE_CELL;
    else if (cfg_we) mode <= cfg_data;
  end

  state_t state, state_next;
  logic accept;
  assign accept = s_axis_tvalid && s_axis_tready;
  logic cellmode, is_last, cell_pick;
  assign cellmode = mode[1];
  assign cell_pick = cellmode && (in_idx == 3'd7);

  logic [TB-1:0] px, py;
  logic [AW-1:0] raddr;
  logic [7:0] rank;
  always_comb begin
    if (cell_pick) begin
      px = in_col[TB-1:0];
      py = in_line[TB-1:0];
    end else begin
      px = TB'({in_col, in_idx[0]});
      py = TB'({in_line, in_idx[2:1]});
    end
    raddr = {py, px};
  end

  bns_rank_mem #(.AW(AW)) u_mem (
    .clk(clk), .we(accept && !s_axis_tuser && 32'(in_naddr) < ENTRIES),
    .waddr(in_naddr[AW-1:0]), .wdata(in_nval), .raddr(raddr), .rdata(rank)
  );

  look_t lk;
  logic [23:0] fg, bg;
  always_ff @(posedge clk) begin
    if (accept) begin
      lk.shade <= shade_of(cell_pick ? in_fg : in_rgb);
      lk.rgb <= in_rgb;
      lk.idx <= in_idx;
      lk.by_cell <= cell_pick;
      fg <= in_fg;
      bg <= in_bg;
    end
  end

  logic [10:0] on_s [3];
  logic [10:0] off_s [3];
  logic [3:0] on_cnt, seen_cnt;
  logic [7:0] imask, bmask, seen;
  logic [13:0] glyph;
  logic [23:0] mfg, mbg;
  logic [2:0] dsel;
  logic dstart, ddone;
  logic [7:0] dq;
  logic [10:0] dnum;
  logic [3:0] dden;
  logic [71:0] obuf;
  logic dot;
  assign dot = lk.shade > 16'(rank) * 16'd257;
  assign is_last = lk.idx == 3'd7;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (accept && s_axis_tuser) state_next = ST_LOOK;
      ST_LOOK: begin
        if (!is_last) state_next = ST_IDLE;
        else if (lk.by_cell) state_next = ST_OUT;
        else state_next = ST_DIV;
      end
      ST_DIV: if (ddone && dsel == 3'd5) state_next = ST_OUT;
      ST_OUT: if (m_axis_tready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = state == ST_IDLE;
    m_axis_tvalid = state == ST_OUT;
    m_axis_tdata = obuf;
  end

  always_comb begin
    if (dsel < 3'd3) begin
      dnum = on_s[2'(dsel)];
      dden = on_cnt;
    end else begin
      dnum = off_s[2'(dsel - 3'd3)];
      dden = 4'(seen_cnt - on_cnt);
    end
  end

  bns_divider u_div (
    .clk(clk), .rst(rst), .start(dstart), .num(dnum), .den(dden),
    .done(ddone), .quo(dq)
  );

  logic new_idx;
  assign new_idx = !seen[lk.idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      dstart <= 1'b0;
      dsel <= '0;
      seen <= '0;
      imask <= '0;
      bmask <= '0;
      on_cnt <= '0;
      seen_cnt <= '0;
      for (int i = 0; i < 3; i++) begin
        on_s[i] <= '0;
        off_s[i] <= '0;
      end
    end else begin
      state <= state_next;
      dstart <= 1'b0;
      if (state == ST_LOOK) begin
        if (lk.by_cell) begin
          if (!dot) glyph <= GLYPH_SPACE;
          else if (32'(lk.shade) * 100 > 82 * 65535) glyph <= GLYPH_DOT4;
          else if (32'(lk.shade) * 100 > 62 * 65535) glyph <= GLYPH_DOT3;
          else if (32'(lk.shade) * 100 > 42 * 65535) glyph <= GLYPH_DOT2;
          else glyph <= GLYPH_DOT1;
        end else if (new_idx) begin
          seen[lk.idx] <= 1'b1;
          seen_cnt <= seen_cnt + 4'd1;
          for (int i = 0; i < 3; i++) begin
            if (dot) on_s[i] <= on_s[i] + 11'(lk.rgb[8*(2-i) +: 8]);
            else off_s[i] <= off_s[i] + 11'(lk.rgb[8*(2-i) +: 8]);
          end
          if (dot) begin
            on_cnt <= on_cnt + 4'd1;
            imask[lk.idx] <= 1'b1;
            bmask <= bmask | braille_bit(lk.idx);
          end
        end
        if (is_last && !lk.by_cell) begin
          dsel <= '0;
          dstart <= 1'b1;
        end
      end
      if (state == ST_DIV && ddone) begin
        unique case (dsel)
          3'd0: mfg[23:16] <= dq;
          3'd1: mfg[15:8] <= dq;
          3'd2: mfg[7:0] <= dq;
          3'd3: mbg[23:16] <= dq;
          3'd4: mbg[15:8] <= dq;
          default: mbg[7:0] <= dq;
        endcase
        if (dsel != 3'd5) begin
          dsel <= dsel + 3'd1;
          dstart <= 1'b1;
        end
      end
      if (state == ST_OUT && m_axis_tready) begin
        seen <= '0;
        imask <= '0;
        bmask <= '0;
        on_cnt <= '0;
        seen_cnt <= '0;
        for (int i = 0; i < 3; i++) begin
          on_s[i] <= '0;
          off_s[i] <= '0;
        end
      end
    end
  end

  always_comb begin
    obuf = '0;
    if (lk.by_cell) begin
      obuf[13:0] = glyph;
      obuf[45:22] = fg;
      obuf[69:46] = bg;
    end else begin
      if (mode == MODE_BRAILLE)
        obuf[13:0] = bmask == 8'd0 ? GLYPH_SPACE : GLYPH_BRAILLE + 14'(bmask);
      obuf[21:14] = imask;
      obuf[45:22] = on_cnt == 4'd0 ? fg : mfg;
      obuf[69:46] = seen_cnt == on_cnt ? bg : mbg;
    end
  end

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE |-> !s_axis_tready) else $error("accept while busy");
  a_on_le_seen: assert property (@(posedge clk) disable iff (rst)
    on_cnt <= seen_cnt) else $error("on count exceeds seen");
  a_seen_cnt: assert property (@(posedge clk) disable iff (rst)
    4'($countones(seen)) == seen_cnt) else $error("seen count mismatch");
  a_out_held: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed under stall");
`endif
endmodule
`default_nettype wire
